// File: hdl/assert_macros.svh
// Assertion macros shared by the frame receiver modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, off while reset is asserted.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/ufr_pkg.sv
// Package of the frame receiver: protocol constants, state enums, job record.
// No dependencies; imported by every module of the block.
package ufr_pkg;

  localparam logic [7:0]  StartByte  = 8'hA5;
  localparam logic [7:0]  NeedAck    = 8'h22;
  localparam logic [7:0]  AckCode    = 8'h12;
  localparam logic [7:0]  AckLenByte = 8'h04;
  localparam logic [7:0]  AckPad     = 8'h00;
  localparam logic [7:0]  ByteAllOne = 8'hFF;
  localparam logic [23:0] TypeA      = 24'h013040;
  localparam logic [23:0] TypeB      = 24'h013140;

  localparam int StoreDepth = 28;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int HeaderLen  = 6;
  localparam int MinAckPay  = 3;
  localparam int JobDepth   = 2;
  localparam int JobAw      = $clog2(JobDepth);
  localparam int JobCntW    = $clog2(JobDepth + 1);

  // Fixed part of the acknowledge checksum: start byte, ack code, length byte.
  localparam logic [7:0] SumSeed = 8'(StartByte + AckCode + AckLenByte);
  localparam logic [3:0] AckLastIdx = 4'd9;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_ACK  = 2'd1,
    BK_REC  = 2'd2
  } back_state_e;

  // Everything the back end needs to replay one finished frame.
  typedef struct packed {
    logic        ack_en;
    logic        rec_en;
    logic [7:0]  ack_b2;
    logic [7:0]  ack_b4;
    logic [7:0]  ack_cs;
    logic [7:0]  ack_b6;
    logic [7:0]  ack_b7;
    logic [7:0]  ack_b8;
    logic [23:0] firmware_version;
    logic [7:0]  power_code;
    logic [7:0]  fan_mode_code;
    logic [7:0]  fan_speed_code;
    logic [7:0]  display_level;
    logic [15:0] particle_reading;
    logic [7:0]  display_lock_code;
    logic [7:0]  auto_mode_code;
    logic [15:0] room_size;
  } job_t;

endpackage

// File: hdl/ufr_front.sv
// Front end: hunts for the start byte, parses header and payload, keeps the frame store.
// Uses ufr_pkg; pushes one job per finished frame that yields results.
`include "assert_macros.svh"

module ufr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    rx_byte_i,
  output logic          full_o,
  input  logic          job_full_i,
  output logic          job_push_o,
  output ufr_pkg::job_t job_o
);
  import ufr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [8:0]  byte_count_q, byte_count_d;
  logic [7:0]  payload_length_q, payload_length_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  store_q [StoreDepth];
  logic [7:0]  store_d [StoreDepth];
  logic        accept;
  logic        done;
  logic [8:0]  total;
  logic [23:0] frame_type;
  logic        ack_en;
  logic        rec_en;

  assign accept = push_i & ~job_full_i;
  assign full_o = job_full_i;

  always_comb begin
    phase_d          = phase_q;
    byte_count_d     = byte_count_q;
    payload_length_d = payload_length_q;
    sum_d            = sum_q;
    done             = 1'b0;
    for (int i = 0; i < StoreDepth; i++) begin
      store_d[i] = store_q[i];
    end
    if (accept) begin
      case (phase_q)
        PH_HEADER, PH_PAYLOAD: begin
          if (byte_count_q < 9'(StoreDepth)) begin
            store_d[byte_count_q[StoreAw-1:0]] = rx_byte_i;
          end
          if (byte_count_q == 9'd2 || byte_count_q == 9'd4 || byte_count_q == 9'd6 ||
              byte_count_q == 9'd7 || byte_count_q == 9'd8) begin
            sum_d = sum_q + rx_byte_i;
          end
          byte_count_d = byte_count_q + 9'd1;
          if (phase_q == PH_HEADER) begin
            if (byte_count_q == 9'd3) begin
              payload_length_d = rx_byte_i;
            end
            if (byte_count_d >= 9'(HeaderLen)) begin
              if (payload_length_d == 8'd0) begin
                phase_d = PH_HUNT;
                done    = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end else if (byte_count_d >= {1'b0, payload_length_q} + 9'(HeaderLen)) begin
            phase_d = PH_HUNT;
            done    = 1'b1;
          end
        end
        default: begin
          // Hunt; an unused phase code behaves the same.
          phase_d = PH_HUNT;
          if (rx_byte_i == StartByte) begin
            store_d[0]       = rx_byte_i;
            byte_count_d     = 9'd1;
            payload_length_d = 8'd0;
            sum_d            = SumSeed;
            phase_d          = PH_HEADER;
          end
        end
      endcase
    end
  end

  // Build the job from the updated store so the closing byte is included.
  assign total      = {1'b0, payload_length_d} + 9'(HeaderLen);
  assign frame_type = {store_d[6], store_d[7], store_d[8]};
  assign ack_en     = (store_d[1] == NeedAck) && (payload_length_d >= 8'(MinAckPay));
  assign rec_en     = (total == 9'(StoreDepth)) &&
                      ((frame_type == TypeA) || (frame_type == TypeB));
  assign job_push_o = done & (ack_en | rec_en);

  always_comb begin
    job_o.ack_en            = ack_en;
    job_o.rec_en            = rec_en;
    job_o.ack_b2            = store_d[2];
    job_o.ack_b4            = store_d[4];
    job_o.ack_cs            = ByteAllOne - sum_d;
    job_o.ack_b6            = store_d[6];
    job_o.ack_b7            = store_d[7];
    job_o.ack_b8            = store_d[8];
    job_o.firmware_version  = {store_d[12], store_d[11], store_d[10]};
    job_o.power_code        = store_d[13];
    job_o.fan_mode_code     = store_d[14];
    job_o.fan_speed_code    = store_d[18];
    job_o.display_level     = store_d[16];
    job_o.particle_reading  = {store_d[22], store_d[21]};
    job_o.display_lock_code = store_d[23];
    job_o.auto_mode_code    = store_d[24];
    job_o.room_size         = {store_d[26], store_d[25]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HUNT;
      byte_count_q     <= 9'd0;
      payload_length_q <= 8'd0;
      sum_q            <= 8'd0;
    end else begin
      phase_q          <= phase_d;
      byte_count_q     <= byte_count_d;
      payload_length_q <= payload_length_d;
      sum_q            <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < StoreDepth; i++) begin
      store_q[i] <= store_d[i];
    end
  end

  `ASSERT_RST(a_push_ends_frame, job_push_o |=> (phase_q == PH_HUNT), "job pushed mid-frame")

endmodule

// File: hdl/ufr_job_fifo.sv
// Short job queue between front and back end.
// Uses ufr_pkg for the job record and the queue depth.
`include "assert_macros.svh"

module ufr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ufr_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ufr_pkg::job_t data_o
);
  import ufr_pkg::*;

  job_t               mem_q [JobDepth];
  logic [JobAw-1:0]   wr_ptr_q;
  logic [JobAw-1:0]   rd_ptr_q;
  logic [JobCntW-1:0] cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == JobCntW'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == JobAw'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == JobAw'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_RST(a_cnt_bound, cnt_q <= JobCntW'(JobDepth), "job count beyond depth")
  `ASSERT_RST(a_no_pop_empty, pop_i |-> (cnt_q != '0), "job popped from empty queue")

endmodule

// File: hdl/ufr_back.sv
// Back end: replays a queued job as acknowledge bytes and/or a status record.
// Uses ufr_pkg; drives the result register seen on the output queue ports.
`include "assert_macros.svh"

module ufr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_empty_i,
  input  ufr_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic          kind_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_o,
  output logic [23:0]   firmware_version_o,
  output logic [7:0]    power_code_o,
  output logic [7:0]    fan_mode_code_o,
  output logic [7:0]    fan_speed_code_o,
  output logic [7:0]    display_level_o,
  output logic [15:0]   particle_reading_o,
  output logic [7:0]    display_lock_code_o,
  output logic [7:0]    auto_mode_code_o,
  output logic [15:0]   room_size_o
);
  import ufr_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [23:0] firmware_version;
    logic [7:0]  power_code;
    logic [7:0]  fan_mode_code;
    logic [7:0]  fan_speed_code;
    logic [7:0]  display_level;
    logic [15:0] particle_reading;
    logic [7:0]  display_lock_code;
    logic [7:0]  auto_mode_code;
    logic [15:0] room_size;
  } res_t;

  back_state_e state_q, state_d;
  logic [3:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;
  logic        out_free;
  logic        load;
  logic [7:0]  ack_byte;

  assign out_free = ~out_valid_q | pop_i;

  always_comb begin
    case (idx_q)
      4'd0:    ack_byte = StartByte;
      4'd1:    ack_byte = AckCode;
      4'd2:    ack_byte = job_i.ack_b2;
      4'd3:    ack_byte = AckLenByte;
      4'd4:    ack_byte = job_i.ack_b4;
      4'd5:    ack_byte = job_i.ack_cs;
      4'd6:    ack_byte = job_i.ack_b6;
      4'd7:    ack_byte = job_i.ack_b7;
      4'd8:    ack_byte = job_i.ack_b8;
      default: ack_byte = AckPad;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    job_pop_o = 1'b0;
    load      = 1'b0;
    res_d     = '0;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          idx_d   = 4'd0;
          state_d = job_i.ack_en ? BK_ACK : BK_REC;
        end
      end
      BK_ACK: begin
        if (out_free) begin
          load          = 1'b1;
          res_d.kind    = 1'b0;
          res_d.tx_byte = ack_byte;
          res_d.last    = (idx_q == AckLastIdx) & ~job_i.rec_en;
          if (idx_q == AckLastIdx) begin
            if (job_i.rec_en) begin
              state_d = BK_REC;
            end else begin
              job_pop_o = 1'b1;
              state_d   = BK_IDLE;
            end
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      BK_REC: begin
        if (out_free) begin
          load                    = 1'b1;
          res_d.kind              = 1'b1;
          res_d.last              = 1'b1;
          res_d.firmware_version  = job_i.firmware_version;
          res_d.power_code        = job_i.power_code;
          res_d.fan_mode_code     = job_i.fan_mode_code;
          res_d.fan_speed_code    = job_i.fan_speed_code;
          res_d.display_level     = job_i.display_level;
          res_d.particle_reading  = job_i.particle_reading;
          res_d.display_lock_code = job_i.display_lock_code;
          res_d.auto_mode_code    = job_i.auto_mode_code;
          res_d.room_size         = job_i.room_size;
          job_pop_o               = 1'b1;
          state_d                 = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Hold the result until popped; reload in the same cycle it drains.
  assign out_valid_d = load | (out_valid_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign empty_o             = ~out_valid_q;
  assign kind_o              = res_q.kind;
  assign tx_byte_o           = res_q.tx_byte;
  assign last_o              = res_q.last;
  assign firmware_version_o  = res_q.firmware_version;
  assign power_code_o        = res_q.power_code;
  assign fan_mode_code_o     = res_q.fan_mode_code;
  assign fan_speed_code_o    = res_q.fan_speed_code;
  assign display_level_o     = res_q.display_level;
  assign particle_reading_o  = res_q.particle_reading;
  assign display_lock_code_o = res_q.display_lock_code;
  assign auto_mode_code_o    = res_q.auto_mode_code;
  assign room_size_o         = res_q.room_size;

  `ASSERT_RST(a_busy_has_job, (state_q != BK_IDLE) |-> !job_empty_i, "replay without a job")
  `ASSERT_RST(a_ack_idx_range, (state_q == BK_ACK) |-> (idx_q <= AckLastIdx), "ack index overrun")

endmodule

// File: hdl/uart_frame_receiver_with_ack.sv
// Frame receiver with acknowledge: one received byte per transfer, up to 11 results per frame.
// Throughput: one byte a cycle while full is low; a finished frame's job is queued.
// The back end replays it, one result a cycle into the result register while pop keeps up.
// The two-entry job queue sets how many finished frames may wait; full rises when it fills.
// Reset: asynchronous, active low; clears parser, queue and result valid, no clearing pass.
module uart_frame_receiver_with_ack (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [23:0] firmware_version_o,
  output logic [7:0]  power_code_o,
  output logic [7:0]  fan_mode_code_o,
  output logic [7:0]  fan_speed_code_o,
  output logic [7:0]  display_level_o,
  output logic [15:0] particle_reading_o,
  output logic [7:0]  display_lock_code_o,
  output logic [7:0]  auto_mode_code_o,
  output logic [15:0] room_size_o
);
  import ufr_pkg::*;

  // Job transfer between front end and queue, and queue and back end.
  job_t job_in;
  job_t job_head;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;

  // Front end: parse the byte stream and snapshot each finished frame as a job.
  // It keeps taking bytes while the back end replays earlier frames, unless the job queue is full.
  ufr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Queue: decouple parsing from result delivery.
  ufr_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_head)
  );

  // Back end: replay the head job as ten acknowledge bytes and/or one status
  // record, marking the final one with last; drop the job after its last result.
  ufr_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_empty_i         (job_empty),
    .job_i               (job_head),
    .job_pop_o           (job_pop),
    .empty_o             (empty),
    .pop_i               (pop),
    .kind_o              (kind_o),
    .tx_byte_o           (tx_byte_o),
    .last_o              (last_o),
    .firmware_version_o  (firmware_version_o),
    .power_code_o        (power_code_o),
    .fan_mode_code_o     (fan_mode_code_o),
    .fan_speed_code_o    (fan_speed_code_o),
    .display_level_o     (display_level_o),
    .particle_reading_o  (particle_reading_o),
    .display_lock_code_o (display_lock_code_o),
    .auto_mode_code_o    (auto_mode_code_o),
    .room_size_o         (room_size_o)
  );

endmodule

// File: verif/tb_uart_frame_receiver_with_ack.sv
// Testbench of the frame receiver: streams framed bytes, predicts acknowledge
// bytes and status records, and checks each result transfer. Needs ufr_pkg and
// the uart_frame_receiver_with_ack RTL.
module tb_uart_frame_receiver_with_ack;
  import ufr_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 12;
  localparam int CycleLimit  = 200000;
  // Allow a wide margin after the closing byte for any result still to show.
  localparam int DrainCycles = 20;
  localparam int RandomBytes = 30;
  localparam int AckLen      = 10;
  localparam int LenIdx      = 3;
  localparam int CsumIdx     = 5;
  localparam int FullPayload = StoreDepth - HeaderLen;
  localparam int FillRandom  = -1;

  localparam logic KindAck = 1'b0;
  localparam logic KindRec = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [23:0] firmware_version;
    logic [7:0]  power_code;
    logic [7:0]  fan_mode_code;
    logic [7:0]  fan_speed_code;
    logic [7:0]  display_level;
    logic [15:0] particle_reading;
    logic [7:0]  display_lock_code;
    logic [7:0]  auto_mode_code;
    logic [15:0] room_size;
  } result_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [23:0] firmware_version_o;
  logic [7:0]  power_code_o;
  logic [7:0]  fan_mode_code_o;
  logic [7:0]  fan_speed_code_o;
  logic [7:0]  display_level_o;
  logic [15:0] particle_reading_o;
  logic [7:0]  display_lock_code_o;
  logic [7:0]  auto_mode_code_o;
  logic [15:0] room_size_o;

  uart_frame_receiver_with_ack dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte_i),
    .empty              (empty),
    .pop                (pop),
    .kind_o             (kind_o),
    .tx_byte_o          (tx_byte_o),
    .last_o             (last_o),
    .firmware_version_o (firmware_version_o),
    .power_code_o       (power_code_o),
    .fan_mode_code_o    (fan_mode_code_o),
    .fan_speed_code_o   (fan_speed_code_o),
    .display_level_o    (display_level_o),
    .particle_reading_o (particle_reading_o),
    .display_lock_code_o(display_lock_code_o),
    .auto_mode_code_o   (auto_mode_code_o),
    .room_size_o        (room_size_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame parser mirror. Updated once per accepted byte; every result the
  // block owes is appended to pending_results in emission order.
  // ---------------------------------------------------------------------------
  phase_e      fr_phase = PH_HUNT;
  logic [8:0]  fr_count = '0;
  logic [7:0]  fr_len   = '0;
  logic [7:0]  fr_store [StoreDepth];
  result_t     pending_results [$];

  int fail_count        = 0;
  int bytes_counted     = 0;   // bytes that were not dropped while hunting

  // Emit the acknowledge and/or status record owed by the frame just closed.
  function automatic void close_frame();
    logic [7:0]  ack [AckLen];
    logic [7:0]  csum;
    logic [23:0] frame_type;
    logic        ack_on;
    logic        rec_on;
    result_t     r;
    int          i;
    ack_on     = (fr_store[1] == NeedAck) && (fr_len >= MinAckPay);
    frame_type = {fr_store[6], fr_store[7], fr_store[8]};
    rec_on     = (int'(fr_len) + HeaderLen == StoreDepth) &&
                 (frame_type == TypeA || frame_type == TypeB);
    if (ack_on) begin
      // Echo frame bytes 0..8, patch the code and length, pad with zero,
      // then fold everything else into the checksum slot.
      for (i = 0; i < AckLen - 1; i++) ack[i] = fr_store[i];
      ack[AckLen - 1] = AckPad;
      ack[1]          = AckCode;
      ack[LenIdx]     = AckLenByte;
      ack[CsumIdx]    = 8'h00;
      csum = ByteAllOne;
      for (i = 0; i < AckLen; i++) csum = csum - ack[i];
      ack[CsumIdx] = csum;
      for (i = 0; i < AckLen; i++) begin
        r         = '0;
        r.kind    = KindAck;
        r.tx_byte = ack[i];
        r.last    = (i == AckLen - 1) && !rec_on;
        pending_results.insert(pending_results.size(), r);
      end
    end
    if (rec_on) begin
      r                   = '0;
      r.kind              = KindRec;
      r.last              = 1'b1;
      r.firmware_version  = {fr_store[12], fr_store[11], fr_store[10]};
      r.power_code        = fr_store[13];
      r.fan_mode_code     = fr_store[14];
      r.fan_speed_code    = fr_store[18];
      r.display_level     = fr_store[16];
      r.particle_reading  = {fr_store[22], fr_store[21]};
      r.display_lock_code = fr_store[23];
      r.auto_mode_code    = fr_store[24];
      r.room_size         = {fr_store[26], fr_store[25]};
      pending_results.insert(pending_results.size(), r);
    end
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    case (fr_phase)
      PH_HEADER: begin
        if (fr_count < StoreDepth) fr_store[fr_count] = b;
        if (fr_count == LenIdx) fr_len = b;
        fr_count = fr_count + 9'd1;
        if (fr_count >= HeaderLen) begin
          if (fr_len == 8'd0) begin
            // Zero payload: the frame closes on the last header byte.
            fr_phase = PH_HUNT;
            close_frame();
          end else begin
            fr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        // Bytes beyond the store are counted but dropped.
        if (fr_count < StoreDepth) fr_store[fr_count] = b;
        fr_count = fr_count + 9'd1;
        if (int'(fr_count) >= int'(fr_len) + HeaderLen) begin
          fr_phase = PH_HUNT;
          close_frame();
        end
      end
      default: begin
        // Hunt: anything but the start byte is dropped.
        fr_phase = PH_HUNT;
        if (b == StartByte) begin
          fr_store[0] = b;
          fr_count    = 9'd1;
          fr_len      = 8'd0;
          fr_phase    = PH_HEADER;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender. Works in bursts; gap_max of zero turns idling off.
  // push stays high between calls so back-to-back bytes see no bubble.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_max    = 0;

  task automatic send_byte(input logic [7:0] b);
    int gap;
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    // Hold the byte until the block takes it.
    while (full) @(posedge clk_i);
    if (fr_phase == PH_HEADER || fr_phase == PH_PAYLOAD || b == StartByte)
      bytes_counted++;
    decode_rx_byte(b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Send one frame: start byte, header, then pay_len payload bytes whose
  // first three carry frame_type. fill picks the remaining bytes: a byte
  // value, or FillRandom.
  task automatic send_frame(input logic [7:0] ack_flag, input logic [7:0] pay_len,
                            input logic [23:0] frame_type, input int fill);
    logic [7:0] b;
    int         idx;
    send_byte(StartByte);
    send_byte(ack_flag);
    send_byte((fill == FillRandom) ? 8'($urandom) : 8'(fill));
    send_byte(pay_len);
    send_byte((fill == FillRandom) ? 8'($urandom) : 8'(fill));
    send_byte((fill == FillRandom) ? 8'($urandom) : 8'(fill));
    for (idx = HeaderLen; idx < HeaderLen + int'(pay_len); idx++) begin
      if (idx < HeaderLen + 3)
        b = frame_type[8 * (HeaderLen + 2 - idx) +: 8];
      else
        b = (fill == FillRandom) ? 8'($urandom) : 8'(fill);
      send_byte(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop follows its own stall pattern, re-drawn every window,
  // and some windows never stall.
  // ---------------------------------------------------------------------------
  int stall_window = 0;
  int stall_period = 1;
  int stall_len    = 0;
  int stall_tick   = 0;

  always @(posedge clk_i) begin
    if (stall_window == 0) begin
      stall_window = 48;
      stall_period = $urandom_range(2, 9);
      stall_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      stall_tick   = 0;
    end
    stall_window--;
    stall_tick++;
    pop <= (stall_tick % stall_period) >= stall_len;
  end

  function automatic void compare_field(input string fld_name, input logic [23:0] want,
                                        input logic [23:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fld_name, want, got);
      fail_count++;
    end
  endfunction

  // Match each result transfer against the oldest pending expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: kind %0b tx_byte 0x%0h",
               kind_o, tx_byte_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", want.kind, kind_o);
        compare_field("tx_byte", want.tx_byte, tx_byte_o);
        compare_field("last", want.last, last_o);
        compare_field("firmware_version", want.firmware_version, firmware_version_o);
        compare_field("power_code", want.power_code, power_code_o);
        compare_field("fan_mode_code", want.fan_mode_code, fan_mode_code_o);
        compare_field("fan_speed_code", want.fan_speed_code, fan_speed_code_o);
        compare_field("display_level", want.display_level, display_level_o);
        compare_field("particle_reading", want.particle_reading, particle_reading_o);
        compare_field("display_lock_code", want.display_lock_code, display_lock_code_o);
        compare_field("auto_mode_code", want.auto_mode_code, auto_mode_code_o);
        compare_field("room_size", want.room_size, room_size_o);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_uart_frame_receiver_with_ack NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Drop garbage while hunting, then close a frame on its header alone.
  task automatic test_hunt_and_zero_payload();
    gap_max = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(StartByte - 8'd1);
    send_frame(NeedAck, 8'd0, '0, FillRandom);
  endtask

  // Two payload bytes make no acknowledge; three make the shortest one.
  task automatic test_short_payload();
    gap_max = 2;
    send_frame(NeedAck, 8'd2, TypeA, FillRandom);
    send_frame(NeedAck, 8'd3, TypeB, 8'h00);
  endtask

  // Full-length status frames: all-ones fields with acknowledge, then one
  // without acknowledge that repeats the start byte through its body.
  task automatic test_status_records();
    gap_max = 3;
    send_frame(NeedAck, 8'(FullPayload), TypeA, 8'hFF);
    send_frame(8'h00, 8'(FullPayload), TypeB, StartByte);
  endtask

  // A frame longer than the store still acknowledges but makes no record;
  // a near-miss type at full length makes nothing.
  task automatic test_long_and_wrong_type();
    gap_max = 1;
    send_frame(NeedAck, 8'(FullPayload + 3), TypeA, FillRandom);
    send_frame(8'h21, 8'(FullPayload), TypeA ^ 24'h000001, FillRandom);
  endtask

  // Mostly well-formed frames with random content; noise and cut-off frames
  // in between so the parser also sees broken sequences.
  task automatic test_random_traffic();
    int          start_bytes;
    int          sel;
    logic [7:0]  flag;
    logic [7:0]  len;
    logic [23:0] ftype;
    start_bytes = bytes_counted;
    while (bytes_counted - start_bytes < RandomBytes) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      flag    = ($urandom_range(0, 9) < 6) ? NeedAck : 8'($urandom);
      sel     = $urandom_range(0, 99);
      if (sel < 40)      len = 8'(FullPayload);
      else if (sel < 70) len = 8'($urandom_range(0, 5));
      else if (sel < 97) len = 8'($urandom_range(6, 40));
      else               len = 8'($urandom_range(200, 255));
      sel = $urandom_range(0, 9);
      if (sel < 4)       ftype = TypeA;
      else if (sel < 8)  ftype = TypeB;
      else if (sel == 8) ftype = TypeB ^ (24'h1 << $urandom_range(0, 23));
      else               ftype = 24'($urandom);
      send_frame(flag, len, ftype, FillRandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (sel == 1) begin
        // Cut a frame short; the next start byte lands inside it as data.
        send_byte(StartByte);
        send_byte(NeedAck);
      end
    end
  endtask

  initial begin
    // Hold reset, then release it on a clock edge.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_hunt_and_zero_payload();
    test_short_payload();
    test_status_records();
    test_long_and_wrong_type();
    test_random_traffic();

    // Drop push, drain what is owed, then give stray results time to show.
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_uart_frame_receiver_with_ack OK");
    end else begin
      $display("tb_uart_frame_receiver_with_ack NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ufr_pkg.sv
hdl/ufr_front.sv
hdl/ufr_job_fifo.sv
hdl/ufr_back.sv
hdl/uart_frame_receiver_with_ack.sv
verif/tb_uart_frame_receiver_with_ack.sv
